### rtl/tte_pkg.sv
// Shared types and constants for the tap tempo estimator.
// No dependencies; used by tte_div and tap_tempo_estimator_core.
package tte_pkg;

  localparam int unsigned HISTORY_DEF = 8;

  localparam int unsigned TS_W      = 48;
  localparam int unsigned TIMEOUT_W = 26;
  localparam int unsigned BPM_W     = 17;
  localparam int unsigned NUSED_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 26;

  // Divider operands: 2*6e9*n + span and 2*span, both below 2^49.
  localparam int unsigned NUM_W = 49;
  localparam int unsigned DEN_W = 49;

  // Twice 6e9: minutes-to-microseconds times 100, doubled for round-half-up.
  localparam logic [NUM_W-1:0] BPM_NUMER2 = NUM_W'(64'd12000000000);

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(2000000);
  localparam logic [BPM_W-1:0]     MIN_BPM_RST = BPM_W'(2000);
  localparam logic [BPM_W-1:0]     MAX_BPM_RST = BPM_W'(99900);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_MIN_BPM = 2'd1,
    CFG_MAX_BPM = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_WRITE,
    ST_RD_OLD,
    ST_DIV,
    ST_FIN
  } tte_state_e;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/tte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tte_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/tte_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tte_pkg for the status struct.
module tte_div #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned DEN_W = 49
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output tte_pkg::div_status_t status_o,
  output logic [NUM_W-1:0]    quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] qn_q, qn_d;   // numerator shifts out, quotient shifts in
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, qn_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    qn_d   = qn_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      qn_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      qn_d  = {qn_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qn_q  <= qn_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quo_o         = qn_q;

endmodule

### rtl/tap_tempo_estimator_core.sv
// Tap tempo estimator top level: sequencer, tap ring and clamp logic.
// Depends on tte_pkg, tte_ram and tte_div.
//
// For a tap that yields an estimate, the sequencer reads the previous tap,
// stores the new one and reads the oldest windowed tap. In the divide state the
// bit-serial divider forms round-half-up of 6e9*n/span and then flags
// completion. A last state clamps and loads the result register. A zero span
// skips the divider and goes on to clamp and load the result. A tap that gives
// no result goes back to idle from the store state.
// tap_ready_o is low while a tap is in work. A finished result may wait in its
// register while the next tap is taken; the clamp step holds until that
// register is free. The first tap after a restart (gap above timeout_us) gives
// no result. Tap times live in a RAM of HISTORY entries, which needs no
// clearing after reset.
module tap_tempo_estimator_core #(
  parameter int unsigned HISTORY = tte_pkg::HISTORY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tte_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  // taps
  input  logic                           tap_valid_i,
  output logic                           tap_ready_o,
  input  logic [tte_pkg::TS_W-1:0]       tap_time_us_i,
  // results
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [tte_pkg::BPM_W-1:0]      bpm_x100_o,
  output logic [tte_pkg::NUSED_W-1:0]    intervals_used_o,
  output logic                           was_clamped_o
);

  localparam int unsigned SLOT_W = $clog2(HISTORY);
  localparam int unsigned HELD_W = $clog2(HISTORY + 1);
  localparam int unsigned TS_W   = tte_pkg::TS_W;
  localparam int unsigned NUM_W  = tte_pkg::NUM_W;
  localparam int unsigned DEN_W  = tte_pkg::DEN_W;
  localparam int unsigned BPM_W  = tte_pkg::BPM_W;

  // (from - back) modulo HISTORY, both below HISTORY
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] from,
                                                  input logic [SLOT_W-1:0] back);
    logic [SLOT_W:0] sum;
    sum = {1'b0, from} + (SLOT_W + 1)'(HISTORY) - {1'b0, back};
    if (from >= back) begin
      return SLOT_W'(from - back);
    end
    return sum[SLOT_W-1:0];
  endfunction

  tte_pkg::tte_state_e state_q, state_d;

  logic [tte_pkg::TIMEOUT_W-1:0] timeout_q, timeout_d;
  logic [BPM_W-1:0]              min_q, min_d;
  logic [BPM_W-1:0]              max_q, max_d;

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic [HELD_W-1:0] held_inc;
  logic [TS_W-1:0]   now_q, now_d;
  logic [SLOT_W-1:0] n_q, n_d;
  logic [NUM_W-1:0]  prod_q, prod_d;
  logic              zero_q, zero_d;

  logic              res_valid_q, res_valid_d;
  logic [BPM_W-1:0]  bpm_q, bpm_d;
  logic [SLOT_W-1:0] used_q, used_d;
  logic              clamp_q, clamp_d;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_raddr;
  logic [TS_W-1:0]   ram_rdata;
  logic [TS_W-1:0]   diff;

  logic                 div_start;
  logic [NUM_W-1:0]     div_num;
  logic [DEN_W-1:0]     div_den;
  logic [NUM_W-1:0]     div_quo;
  tte_pkg::div_status_t div_st;

  assign diff     = now_q - ram_rdata;   // modulo 2^48
  assign held_inc = (held_q == HELD_W'(HISTORY)) ? held_q : held_q + HELD_W'(1);
  assign div_num  = prod_q + NUM_W'(diff);
  assign div_den  = {diff, 1'b0};

  always_comb begin
    state_d     = state_q;
    timeout_d   = timeout_q;
    min_d       = min_q;
    max_d       = max_q;
    slot_d      = slot_q;
    held_d      = held_q;
    now_d       = now_q;
    n_d         = n_q;
    prod_d      = prod_q;
    zero_d      = zero_q;
    res_valid_d = res_valid_q;
    bpm_d       = bpm_q;
    used_d      = used_q;
    clamp_d     = clamp_q;
    ram_we      = 1'b0;
    ram_raddr   = slot_back(slot_q, SLOT_W'(1));
    div_start   = 1'b0;
    tap_ready_o = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        tte_pkg::CFG_TIMEOUT: timeout_d = cfg_wdata_i;
        tte_pkg::CFG_MIN_BPM: min_d     = cfg_wdata_i[BPM_W-1:0];
        tte_pkg::CFG_MAX_BPM: max_d     = cfg_wdata_i[BPM_W-1:0];
        default: ;
      endcase
    end

    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      tte_pkg::ST_IDLE: begin
        tap_ready_o = 1'b1;
        if (tap_valid_i) begin
          now_d   = tap_time_us_i;
          state_d = (held_q != '0) ? tte_pkg::ST_RD_LAST : tte_pkg::ST_WRITE;
        end
      end
      tte_pkg::ST_RD_LAST: begin
        if (diff > TS_W'(timeout_q)) begin
          held_d = '0;
        end
        state_d = tte_pkg::ST_WRITE;
      end
      tte_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        slot_d    = (slot_q == SLOT_W'(HISTORY - 1)) ? '0 : slot_q + SLOT_W'(1);
        held_d    = held_inc;
        n_d       = SLOT_W'(held_inc - HELD_W'(1));
        prod_d    = tte_pkg::BPM_NUMER2 * NUM_W'(n_d);
        ram_raddr = slot_back(slot_q, n_d);
        state_d   = (held_inc < HELD_W'(2)) ? tte_pkg::ST_IDLE : tte_pkg::ST_RD_OLD;
      end
      tte_pkg::ST_RD_OLD: begin
        zero_d = (diff == '0);
        if (diff == '0) begin
          state_d = tte_pkg::ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = tte_pkg::ST_DIV;
        end
      end
      tte_pkg::ST_DIV: begin
        if (div_st.done) begin
          state_d = tte_pkg::ST_FIN;
        end
      end
      tte_pkg::ST_FIN: begin
        if (!res_valid_q || res_ready_i) begin
          res_valid_d = 1'b1;
          used_d      = n_q;
          if (zero_q || div_quo > NUM_W'(max_q)) begin
            bpm_d   = max_q;
            clamp_d = 1'b1;
          end else if (div_quo < NUM_W'(min_q)) begin
            bpm_d   = min_q;
            clamp_d = 1'b1;
          end else begin
            bpm_d   = div_quo[BPM_W-1:0];
            clamp_d = 1'b0;
          end
          state_d = tte_pkg::ST_IDLE;
        end
      end
      default: state_d = tte_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tte_pkg::ST_IDLE;
      timeout_q   <= tte_pkg::TIMEOUT_RST;
      min_q       <= tte_pkg::MIN_BPM_RST;
      max_q       <= tte_pkg::MAX_BPM_RST;
      slot_q      <= '0;
      held_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      timeout_q   <= timeout_d;
      min_q       <= min_d;
      max_q       <= max_d;
      slot_q      <= slot_d;
      held_q      <= held_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    n_q     <= n_d;
    prod_q  <= prod_d;
    zero_q  <= zero_d;
    bpm_q   <= bpm_d;
    used_q  <= used_d;
    clamp_q <= clamp_d;
  end

  tte_ram #(
    .WIDTH (TS_W),
    .DEPTH (HISTORY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (now_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tte_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .status_o (div_st),
    .quo_o    (div_quo)
  );

  assign res_valid_o      = res_valid_q;
  assign bpm_x100_o       = bpm_q;
  assign intervals_used_o = tte_pkg::NUSED_W'(used_q);
  assign was_clamped_o    = clamp_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HELD_W'(HISTORY))
    else $error("tap count above history depth");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(HISTORY - 1))
    else $error("write slot out of range");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> state_q == tte_pkg::ST_DIV)
    else $error("divider running outside divide state");

  a_result_needs_taps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> held_q >= HELD_W'(2))
    else $error("result issued with fewer than two taps");

  a_write_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tap_valid_i && tap_ready_o && held_q == '0) |=> state_q == tte_pkg::ST_WRITE)
    else $error("first tap did not go straight to store");

endmodule
